[design/uvd_pkg.sv]
// Shared types, codes and a helper function of the UTF-8 style varint decoder.
package uvd_pkg;

  // Number of continuation lanes: one for each window byte after the lead.
  localparam int unsigned NumLanes = 8;

  // Target width codes.
  localparam logic [1:0] WIDTH_16     = 2'd0;
  localparam logic [1:0] WIDTH_32     = 2'd1;
  localparam logic [1:0] WIDTH_64     = 2'd2;
  localparam logic [1:0] WIDTH_UNUSED = 2'd3;

  // Lead byte forms.
  localparam logic [7:0] RAW_LEAD  = 8'hFF;
  localparam logic [7:0] CONT_MIN  = 8'h80;
  localparam logic [7:0] MULTI_MIN = 8'hC0;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StShort = 2'd1,
    StBad   = 2'd2
  } status_e;

  // What one lane finds in its byte.
  typedef struct packed {
    logic       cont_ok;
    logic [5:0] payload;
    logic [7:0] raw;
  } lane_t;

  // Registered item after the lane stage.
  typedef struct packed {
    logic [1:0]                 value_width;
    logic [3:0]                 bytes_available;
    logic [7:0]                 lead;
    lane_t [NumLanes-1:0]       lanes;
  } stage_t;

  // One decoded result.
  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  consumed;
    status_e     status;
  } result_t;

  // Sequence length from the count of leading ones of a multi-byte lead.
  function automatic logic [2:0] lead_length(input logic [7:0] lead);
    logic [2:0] len;
    len = 3'd0;
    casez (lead)
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      8'b111110??: len = 3'd5;
      8'b1111110?: len = 3'd6;
      8'b11111110: len = 3'd7;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

[design/uvd_if.sv]
// Valid/ready channel interfaces for decoder items and results.
interface uvd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] value_width;
  logic [3:0] bytes_available;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] byte6;
  logic [7:0] byte7;
  logic [7:0] byte8;

  modport source (
    output valid, value_width, bytes_available,
    output byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7, byte8,
    input  ready
  );
  modport sink (
    input  valid, value_width, bytes_available,
    input  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7, byte8,
    output ready
  );
endinterface

interface uvd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] decoded_value;
  logic [3:0]  bytes_consumed;
  logic [1:0]  decode_status;

  modport source (
    output valid, decoded_value, bytes_consumed, decode_status,
    input  ready
  );
  modport sink (
    input  valid, decoded_value, bytes_consumed, decode_status,
    output ready
  );
endinterface

[design/uvd_lane.sv]
// One continuation lane: checks the 10xxxxxx form and extracts six payload bits.
module uvd_lane (
  input  logic [7:0]    byte_i,
  output uvd_pkg::lane_t lane_o
);

  // The top two bits mark a continuation byte; the rest is payload.
  always_comb begin
    lane_o.cont_ok = (byte_i[7:6] == 2'b10);
    lane_o.payload = byte_i[5:0];
    lane_o.raw     = byte_i;
  end

endmodule

[design/uvd_merge.sv]
// Merge stage: combines the lead decode with the lane findings into one result.
module uvd_merge (
  input  uvd_pkg::stage_t  stage_i,
  output uvd_pkg::result_t result_o
);

  logic [2:0]  len;
  logic [2:0]  max_len;
  logic [3:0]  raw_len;
  logic        cont_bad;
  logic [63:0] multi_value;
  logic [63:0] raw_value;
  logic [7:0]  lead;
  uvd_pkg::lane_t [uvd_pkg::NumLanes-1:0] ln;

  assign lead = stage_i.lead;
  assign ln   = stage_i.lanes;
  assign len  = uvd_pkg::lead_length(lead);

  // Width limits for the UTF-8 style form and for the raw escape.
  always_comb begin
    unique case (stage_i.value_width)
      uvd_pkg::WIDTH_16: begin
        max_len = 3'd2;
        raw_len = 4'd3;
      end
      uvd_pkg::WIDTH_32: begin
        max_len = 3'd4;
        raw_len = 4'd5;
      end
      default: begin
        max_len = 3'd7;
        raw_len = 4'd9;
      end
    endcase
  end

  // Any continuation byte inside the sequence that is malformed.
  always_comb begin
    cont_bad = 1'b0;
    for (int unsigned i = 0; i < 6; i++) begin
      if ((3'(i + 1) < len) && !ln[i].cont_ok) begin
        cont_bad = 1'b1;
      end
    end
  end

  // Assemble the lead bits and six bits from each continuation lane.
  always_comb begin
    case (len)
      3'd2: multi_value = 64'({lead[4:0], ln[0].payload});
      3'd3: multi_value = 64'({lead[3:0], ln[0].payload, ln[1].payload});
      3'd4: multi_value = 64'({lead[2:0], ln[0].payload, ln[1].payload,
                               ln[2].payload});
      3'd5: multi_value = 64'({lead[1:0], ln[0].payload, ln[1].payload,
                               ln[2].payload, ln[3].payload});
      3'd6: multi_value = 64'({lead[0], ln[0].payload, ln[1].payload,
                               ln[2].payload, ln[3].payload, ln[4].payload});
      3'd7: multi_value = 64'({ln[0].payload, ln[1].payload, ln[2].payload,
                               ln[3].payload, ln[4].payload, ln[5].payload});
      default: multi_value = 64'd0;
    endcase
  end

  // Raw big-endian escape value.
  always_comb begin
    unique case (stage_i.value_width)
      uvd_pkg::WIDTH_16: raw_value = 64'({ln[0].raw, ln[1].raw});
      uvd_pkg::WIDTH_32: raw_value = 64'({ln[0].raw, ln[1].raw, ln[2].raw, ln[3].raw});
      default: raw_value = {ln[0].raw, ln[1].raw, ln[2].raw, ln[3].raw,
                            ln[4].raw, ln[5].raw, ln[6].raw, ln[7].raw};
    endcase
  end

  // Status priority: empty window, bad width, lead form, length, continuation.
  always_comb begin
    result_o.value    = 64'd0;
    result_o.consumed = 4'd0;
    result_o.status   = uvd_pkg::StOk;
    if (stage_i.bytes_available == 4'd0) begin
      result_o.status = uvd_pkg::StShort;
    end else if (stage_i.value_width == uvd_pkg::WIDTH_UNUSED) begin
      result_o.status = uvd_pkg::StBad;
    end else if (lead < uvd_pkg::CONT_MIN) begin
      result_o.value    = 64'(lead);
      result_o.consumed = 4'd1;
    end else if (lead < uvd_pkg::MULTI_MIN) begin
      result_o.status = uvd_pkg::StBad;
    end else if (lead == uvd_pkg::RAW_LEAD) begin
      if (stage_i.bytes_available < raw_len) begin
        result_o.status = uvd_pkg::StShort;
      end else begin
        result_o.value    = raw_value;
        result_o.consumed = raw_len;
      end
    end else if (len > max_len) begin
      result_o.status = uvd_pkg::StBad;
    end else if (stage_i.bytes_available < 4'(len)) begin
      result_o.status = uvd_pkg::StShort;
    end else if (cont_bad) begin
      result_o.status = uvd_pkg::StBad;
    end else begin
      result_o.value    = multi_value;
      result_o.consumed = 4'(len);
    end
  end

endmodule

[design/utf8_style_varint_decoder_unit.sv]
// Top level of the UTF-8 style varint decoder: lane stage, merge stage, output register.
// Latency: two register stages; an accepted item is held in the lane register and its
// result enters the output register, which offers it, once that slot is free or taken.
// Throughput: one item per cycle unless the output stalls; the lane register and the
// output register form a two-deep pipeline, advancing when the output is free or taken.
// Reset (rst_ni, asynchronous, active low) empties both pipeline stages.
module utf8_style_varint_decoder_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  uvd_in_if.sink    in_i,
  uvd_out_if.source out_o
);

  logic [7:0] win [uvd_pkg::NumLanes];
  uvd_pkg::lane_t [uvd_pkg::NumLanes-1:0] lanes;
  uvd_pkg::stage_t  stage_d, stage_q;
  uvd_pkg::result_t result_d, result_q;
  logic stage_valid_q;
  logic out_valid_q;
  logic out_adv;

  // Continuation bytes of the window, one per lane.
  assign win[0] = in_i.byte1;
  assign win[1] = in_i.byte2;
  assign win[2] = in_i.byte3;
  assign win[3] = in_i.byte4;
  assign win[4] = in_i.byte5;
  assign win[5] = in_i.byte6;
  assign win[6] = in_i.byte7;
  assign win[7] = in_i.byte8;

  for (genvar g = 0; g < uvd_pkg::NumLanes; g++) begin : gen_lane
    uvd_lane u_lane (
      .byte_i (win[g]),
      .lane_o (lanes[g])
    );
  end

  always_comb begin
    stage_d.value_width     = in_i.value_width;
    stage_d.bytes_available = in_i.bytes_available;
    stage_d.lead            = in_i.byte0;
    stage_d.lanes           = lanes;
  end

  // Pipeline flow control.
  assign out_adv    = !out_valid_q || out_o.ready;
  assign in_i.ready = !stage_valid_q || out_adv;

  // Lane stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stage_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      stage_q <= stage_d;
    end
  end

  uvd_merge u_merge (
    .stage_i  (stage_q),
    .result_o (result_d)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= stage_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && stage_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.decoded_value  = result_q.value;
  assign out_o.bytes_consumed = result_q.consumed;
  assign out_o.decode_status  = result_q.status;

endmodule
